>>> hw/rtl/ssme_pkg.sv
// Shared types, codes and the control store of the small square matrix engine.
`default_nettype none

package ssme_pkg;

    localparam int ORDER_W        = 4;
    localparam int POS_W          = 3;
    localparam int VAL_W          = 32;
    localparam int FUNC_W         = 3;
    localparam int POS_REACH      = 8;
    localparam int MUL_SPLIT      = 32;
    localparam int MAX_ORDER_DEF  = 8;
    localparam int DATA_WIDTH_DEF = 32;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd3;

    typedef enum logic [FUNC_W-1:0] {
        FN_LOAD_A = 3'd0,
        FN_LOAD_B = 3'd1,
        FN_ADD    = 3'd2,
        FN_SUB    = 3'd3,
        FN_MUL    = 3'd4,
        FN_SUMS   = 3'd5
    } t_func;

    localparam int UPC_W = 4;
    typedef logic [UPC_W-1:0] t_upc;

    // microprogram entry points and steps
    localparam t_upc UA_ADD0 = 4'd0;
    localparam t_upc UA_ADD1 = 4'd1;
    localparam t_upc UA_MUL0 = 4'd2;
    localparam t_upc UA_MUL1 = 4'd3;
    localparam t_upc UA_MUL2 = 4'd4;
    localparam t_upc UA_MUL3 = 4'd5;
    localparam t_upc UA_SUM0 = 4'd6;
    localparam t_upc UA_SUM1 = 4'd7;
    localparam t_upc UA_SUM2 = 4'd8;
    localparam t_upc UA_SUM3 = 4'd9;

    typedef enum logic {
        RD_ELEM,
        RD_MAC
    } t_rd_sel;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_MAC,
        ACC_SUM
    } t_acc_op;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_ELEM,
        EM_ACC,
        EM_SUMA,
        EM_SUMB
    } t_emit;

    typedef enum logic [1:0] {
        CNT_NONE,
        CNT_K,
        CNT_IJ
    } t_cnt;

    typedef enum logic [1:0] {
        JMP_NONE,
        JMP_K_MORE,
        JMP_IJ_MORE
    } t_jmp;

    typedef struct packed {
        t_rd_sel rd;
        logic    mul_en;
        t_acc_op acc;
        t_emit   emit;
        t_cnt    cnt;
        t_jmp    jmp;
        logic    fin;
        t_upc    target;
    } t_cword;

    // Control store. A step jumps to target when its condition holds,
    // otherwise ends the run when fin is set, otherwise falls through.
    function automatic t_cword ucode_rom(input t_upc upc);
        t_cword cw;
        cw.rd     = RD_ELEM;
        cw.mul_en = 1'b0;
        cw.acc    = ACC_NONE;
        cw.emit   = EM_NONE;
        cw.cnt    = CNT_NONE;
        cw.jmp    = JMP_NONE;
        cw.fin    = 1'b0;
        cw.target = UA_ADD0;
        case (upc)
            UA_ADD0: begin
                cw.rd = RD_ELEM;
            end
            UA_ADD1: begin
                cw.emit   = EM_ELEM;
                cw.cnt    = CNT_IJ;
                cw.jmp    = JMP_IJ_MORE;
                cw.target = UA_ADD0;
                cw.fin    = 1'b1;
            end
            UA_MUL0: begin
                cw.rd = RD_MAC;
            end
            UA_MUL1: begin
                cw.mul_en = 1'b1;
            end
            UA_MUL2: begin
                cw.acc    = ACC_MAC;
                cw.cnt    = CNT_K;
                cw.jmp    = JMP_K_MORE;
                cw.target = UA_MUL0;
            end
            UA_MUL3: begin
                cw.emit   = EM_ACC;
                cw.cnt    = CNT_IJ;
                cw.jmp    = JMP_IJ_MORE;
                cw.target = UA_MUL0;
                cw.fin    = 1'b1;
            end
            UA_SUM0: begin
                cw.rd = RD_ELEM;
            end
            UA_SUM1: begin
                cw.acc    = ACC_SUM;
                cw.cnt    = CNT_IJ;
                cw.jmp    = JMP_IJ_MORE;
                cw.target = UA_SUM0;
            end
            UA_SUM2: begin
                cw.emit = EM_SUMA;
            end
            UA_SUM3: begin
                cw.emit = EM_SUMB;
                cw.fin  = 1'b1;
            end
            default: begin
                cw.fin = 1'b1;
            end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/small_square_matrix_engine.sv
// Small square matrix engine: matrix stores, microcoded sequencer and datapath.
`default_nettype none

// Holds square matrices A and B (up to MAX_ORDER x MAX_ORDER, at most 8 in use)
// and, on request, streams A+B, A-B or AB in row-major order with a last mark,
// or the element sums of A then B. A load request gives no result. Computation
// runs one request at a time from a microprogram over one read port per matrix
// store and one shared multiply-accumulate unit; a run holds while the output
// side stalls. Values wrap at DATA_WIDTH bits; the output carries the low 32
// bits. Order 0 acts as 1, larger orders clamp to min(MAX_ORDER, 8).
module small_square_matrix_engine #(
    parameter int MAX_ORDER  = ssme_pkg::MAX_ORDER_DEF,
    parameter int DATA_WIDTH = ssme_pkg::DATA_WIDTH_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [ssme_pkg::ORDER_W-1:0]       i_cfg_data,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire  [ssme_pkg::FUNC_W-1:0]        i_func,
    input  wire  [ssme_pkg::POS_W-1:0]         i_row_index,
    input  wire  [ssme_pkg::POS_W-1:0]         i_col_index,
    input  wire  signed [ssme_pkg::VAL_W-1:0]  i_element_value,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic [ssme_pkg::POS_W-1:0]         o_out_row,
    output logic [ssme_pkg::POS_W-1:0]         o_out_col,
    output logic signed [ssme_pkg::VAL_W-1:0]  o_out_value,
    output logic                               o_out_last
);

    localparam int POS_W   = ssme_pkg::POS_W;
    localparam int ORDER_W = ssme_pkg::ORDER_W;
    localparam int DEPTH   = MAX_ORDER * MAX_ORDER;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EFF_MAX = (MAX_ORDER < ssme_pkg::POS_REACH) ? MAX_ORDER
                                                                : ssme_pkg::POS_REACH;

    function automatic logic [ADDR_W-1:0] f_addr(input logic [POS_W-1:0] row,
                                                 input logic [POS_W-1:0] col);
        return ADDR_W'(int'(row) * MAX_ORDER + int'(col));
    endfunction

    // control registers
    logic                  r_busy, n_busy;
    ssme_pkg::t_upc        r_upc, n_upc;
    logic [POS_W-1:0]      r_i, n_i;
    logic [POS_W-1:0]      r_j, n_j;
    logic [POS_W-1:0]      r_k, n_k;
    ssme_pkg::t_func       r_func, n_func;
    logic [ORDER_W-1:0]    r_order;
    logic                  r_out_valid, n_out_valid;

    // datapath registers
    logic [DATA_WIDTH-1:0] mem_a [DEPTH];
    logic [DATA_WIDTH-1:0] mem_b [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_a, r_rd_b;
    logic [DATA_WIDTH-1:0] r_prod;
    logic [DATA_WIDTH-1:0] r_acc_a, r_acc_b;
    logic [POS_W-1:0]      r_out_row, r_out_col;
    logic [DATA_WIDTH-1:0] r_out_value;
    logic                  r_out_last;

    ssme_pkg::t_cword      w_cw;
    logic [ORDER_W-1:0]    w_eff;
    logic [POS_W-1:0]      w_last;
    logic                  w_k_last, w_ij_last, w_take;
    logic                  w_out_free, w_step, w_in_acc, w_start;
    logic                  w_load_ok, w_we_a, w_we_b;
    ssme_pkg::t_upc        w_entry;
    logic [ADDR_W-1:0]     w_waddr, w_raddr_a, w_raddr_b;
    logic [DATA_WIDTH-1:0] w_wdata, w_elem, w_emit_value;
    logic [POS_W-1:0]      w_emit_row, w_emit_col;
    logic                  w_emit_last, w_emit;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_value = ssme_pkg::VAL_W'(r_out_value);
    assign o_out_last  = r_out_last;

    always_comb begin
        if (r_order == '0) begin
            w_eff = ORDER_W'(1);
        end else if (int'(r_order) > EFF_MAX) begin
            w_eff = ORDER_W'(EFF_MAX);
        end else begin
            w_eff = r_order;
        end
    end
    assign w_last = POS_W'(w_eff - ORDER_W'(1));

    assign w_cw       = ssme_pkg::ucode_rom(r_upc);
    assign w_k_last   = (r_k == w_last);
    assign w_ij_last  = (r_i == w_last) && (r_j == w_last);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_emit     = (w_cw.emit != ssme_pkg::EM_NONE);
    // an emitting step holds until the output register can take its result
    assign w_step     = r_busy && (!w_emit || w_out_free);
    assign w_in_acc   = i_in_valid && o_in_ready;

    always_comb begin
        case (w_cw.jmp)
            ssme_pkg::JMP_K_MORE:  w_take = !w_k_last;
            ssme_pkg::JMP_IJ_MORE: w_take = !w_ij_last;
            default:               w_take = 1'b0;
        endcase
    end

    // request decode
    assign w_load_ok = (int'(i_row_index) < MAX_ORDER) && (int'(i_col_index) < MAX_ORDER);
    assign w_waddr   = f_addr(i_row_index, i_col_index);
    assign w_wdata   = DATA_WIDTH'(i_element_value);

    always_comb begin
        w_we_a  = 1'b0;
        w_we_b  = 1'b0;
        w_start = 1'b0;
        w_entry = ssme_pkg::UA_ADD0;
        case (i_func)
            ssme_pkg::FN_LOAD_A: w_we_a = w_in_acc && w_load_ok;
            ssme_pkg::FN_LOAD_B: w_we_b = w_in_acc && w_load_ok;
            ssme_pkg::FN_ADD, ssme_pkg::FN_SUB: begin
                w_start = w_in_acc;
                w_entry = ssme_pkg::UA_ADD0;
            end
            ssme_pkg::FN_MUL: begin
                w_start = w_in_acc;
                w_entry = ssme_pkg::UA_MUL0;
            end
            ssme_pkg::FN_SUMS: begin
                w_start = w_in_acc;
                w_entry = ssme_pkg::UA_SUM0;
            end
            default: begin
                w_start = 1'b0;
            end
        endcase
    end

    // sequencer and loop counters
    always_comb begin
        n_busy = r_busy;
        n_upc  = r_upc;
        n_i    = r_i;
        n_j    = r_j;
        n_k    = r_k;
        n_func = r_func;
        if (w_start) begin
            n_busy = 1'b1;
            n_upc  = w_entry;
            n_i    = '0;
            n_j    = '0;
            n_k    = '0;
            n_func = ssme_pkg::t_func'(i_func);
        end else if (w_step) begin
            case (w_cw.cnt)
                ssme_pkg::CNT_K: begin
                    n_k = w_k_last ? '0 : r_k + POS_W'(1);
                end
                ssme_pkg::CNT_IJ: begin
                    n_k = '0;
                    if (r_j == w_last) begin
                        n_j = '0;
                        n_i = (r_i == w_last) ? '0 : r_i + POS_W'(1);
                    end else begin
                        n_j = r_j + POS_W'(1);
                    end
                end
                default: begin
                    n_k = r_k;
                end
            endcase
            if (w_take) begin
                n_upc = w_cw.target;
            end else if (w_cw.fin) begin
                n_busy = 1'b0;
            end else begin
                n_upc = r_upc + ssme_pkg::UPC_W'(1);
            end
        end
    end

    // result selection
    assign w_elem = (r_func == ssme_pkg::FN_SUB) ? r_rd_a - r_rd_b : r_rd_a + r_rd_b;

    always_comb begin
        w_emit_row   = r_i;
        w_emit_col   = r_j;
        w_emit_last  = w_ij_last;
        w_emit_value = w_elem;
        case (w_cw.emit)
            ssme_pkg::EM_ACC: begin
                w_emit_value = r_acc_a;
            end
            ssme_pkg::EM_SUMA: begin
                w_emit_row   = '0;
                w_emit_col   = '0;
                w_emit_last  = 1'b0;
                w_emit_value = r_acc_a;
            end
            ssme_pkg::EM_SUMB: begin
                w_emit_row   = POS_W'(1);
                w_emit_col   = '0;
                w_emit_last  = 1'b1;
                w_emit_value = r_acc_b;
            end
            default: begin
                w_emit_value = w_elem;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if (w_step && w_emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_upc       <= ssme_pkg::UA_ADD0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_func      <= ssme_pkg::FN_ADD;
            r_order     <= ssme_pkg::ORDER_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_upc       <= n_upc;
            r_i         <= n_i;
            r_j         <= n_j;
            r_k         <= n_k;
            r_func      <= n_func;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_order <= i_cfg_data;
            end
        end
    end

    // matrix stores, one write and one registered read port each
    assign w_raddr_a = (w_cw.rd == ssme_pkg::RD_MAC) ? f_addr(r_i, r_k) : f_addr(r_i, r_j);
    assign w_raddr_b = (w_cw.rd == ssme_pkg::RD_MAC) ? f_addr(r_k, r_j) : f_addr(r_i, r_j);

    always_ff @(posedge i_clk) begin
        if (w_we_a) begin
            mem_a[w_waddr] <= w_wdata;
        end
        r_rd_a <= mem_a[w_raddr_a];
    end

    always_ff @(posedge i_clk) begin
        if (w_we_b) begin
            mem_b[w_waddr] <= w_wdata;
        end
        r_rd_b <= mem_b[w_raddr_b];
    end

    // product wrapped to DATA_WIDTH; wide words split into 32-bit partials
    generate
        if (DATA_WIDTH <= ssme_pkg::MUL_SPLIT) begin : g_mul_one
            logic [DATA_WIDTH-1:0] w_full;
            assign w_full = r_rd_a * r_rd_b;
            always_ff @(posedge i_clk) begin
                if (w_cw.mul_en) begin
                    r_prod <= w_full;
                end
            end
        end else begin : g_mul_split
            localparam int LO_W = ssme_pkg::MUL_SPLIT;
            localparam int HI_W = DATA_WIDTH - LO_W;
            logic [2*LO_W-1:0] w_ll;
            logic [HI_W-1:0]   w_x;
            assign w_ll = (2*LO_W)'(r_rd_a[LO_W-1:0]) * (2*LO_W)'(r_rd_b[LO_W-1:0]);
            assign w_x  = HI_W'(r_rd_a[LO_W-1:0] * r_rd_b[DATA_WIDTH-1:LO_W])
                        + HI_W'(r_rd_a[DATA_WIDTH-1:LO_W] * r_rd_b[LO_W-1:0]);
            always_ff @(posedge i_clk) begin
                if (w_cw.mul_en) begin
                    r_prod <= DATA_WIDTH'(w_ll) + {w_x, {LO_W{1'b0}}};
                end
            end
        end
    endgenerate

    // accumulators: first term of a run loads, later terms add
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            case (w_cw.acc)
                ssme_pkg::ACC_MAC: begin
                    r_acc_a <= (r_k == '0) ? r_prod : r_acc_a + r_prod;
                end
                ssme_pkg::ACC_SUM: begin
                    if (r_i == '0 && r_j == '0) begin
                        r_acc_a <= r_rd_a;
                        r_acc_b <= r_rd_b;
                    end else begin
                        r_acc_a <= r_acc_a + r_rd_a;
                        r_acc_b <= r_acc_b + r_rd_b;
                    end
                end
                default: begin
                    r_acc_a <= r_acc_a;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_emit) begin
            r_out_row   <= w_emit_row;
            r_out_col   <= w_emit_col;
            r_out_value <= w_emit_value;
            r_out_last  <= w_emit_last;
        end
    end

`ifndef NO_ASSERTIONS
    ap_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_busy && !r_out_valid)
        else $error("engine not idle after reset");

    ap_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_i <= w_last) && (r_j <= w_last) && (r_k <= w_last))
        else $error("loop counter beyond order");

    ap_upc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_upc <= ssme_pkg::UA_SUM3)
        else $error("step counter outside program");

    ap_out_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_col <= w_last)
        else $error("result column beyond order");

    ap_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && w_emit && r_out_valid && !i_out_ready |=> $stable(r_upc))
        else $error("emit step advanced into a full output register");
`endif

endmodule

`default_nettype wire
